// ----- sv/djmi_pkg.sv -----
package djmi_pkg;

    localparam int INCOME_W = 16;
    localparam int DUE_W    = 9;
    localparam int SUM_W    = 24;
    localparam int S_DATA_W = 32;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

// ----- sv/djmi_ram.sv -----
module djmi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/deadline_job_max_income_unit.sv -----
// Deadline job scheduler, maximum income.
// Input stream: one beat per job; tdata holds income and due day, tlast marks
// the last job of a set. Output stream: one beat per set, the greatest total
// income reachable with one unit job per day, each on or before its due day.
// Jobs are linked per due day in a head memory and a job memory as they load.
// On tlast the unit walks days from the latest due day down to 1, pushes the
// jobs due that day into a max-heap held in a third memory and pops the
// richest one. Each memory step is a read with a registered output.
// Sums saturate at the top of the 24-bit result.
// After reset the day-list heads, MAX_DUE + 1 entries, are cleared in a pass
// before the first job is taken. The result sits in an output register; the
// next set loads while it waits. If the receiver stalls, a finished sum waits
// in the compute engine until the output register frees.
module deadline_job_max_income_unit
    import djmi_pkg::*;
#(
    parameter int MAX_JOBS = 256,
    parameter int MAX_DUE  = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // income[15:0], due_day[24:16], zero
    input  logic                s_axis_tlast,   // last_job
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [SUM_W-1:0]    m_axis_tdata    // total_income[23:0]
);

    localparam int IW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int PW  = IW + 1;
    localparam int HD  = MAX_DUE + 1;
    localparam int HAW = (HD > 1) ? $clog2(HD) : 1;
    localparam int JW  = INCOME_W + IW + 1;
    localparam int HW  = IW + 1;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_LINK, S_DAY_RD, S_DAY_CHK, S_JOB_CHK, S_PUSH_RD,
        S_PUSH_CMP, S_POP_RD0, S_POP_RD1, S_POP_V, S_SD_RD1, S_SD_RD2,
        S_SD_CMP, S_NEXT_DAY, S_FINISH
    } state_t;

    state_t              state_reg;
    logic [HAW-1:0]      clr_reg;
    logic [PW-1:0]       loaded_reg;
    logic [HAW-1:0]      latest_reg;
    logic [HAW-1:0]      day_reg;
    logic [PW-1:0]       count_reg;
    logic [PW-1:0]       pos_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [INCOME_W-1:0] v_reg;
    logic [INCOME_W-1:0] top_reg;
    logic [INCOME_W-1:0] a_reg;
    logic                bval_reg;
    logic                nvalid_reg;
    logic [IW-1:0]       nidx_reg;
    logic [INCOME_W-1:0] in_inc_reg;
    logic [HAW-1:0]      in_due_reg;
    logic                in_last_reg;
    logic                out_valid_reg;
    logic [SUM_W-1:0]    out_data_reg;

    logic                head_we;
    logic [HAW-1:0]      head_waddr;
    logic [HW-1:0]       head_wdata;
    logic [HAW-1:0]      head_raddr;
    logic [HW-1:0]       head_rdata;
    logic                job_we;
    logic [IW-1:0]       job_waddr;
    logic [JW-1:0]       job_wdata;
    logic [IW-1:0]       job_raddr;
    logic [JW-1:0]       job_rdata;
    logic                heap_we;
    logic [IW-1:0]       heap_waddr;
    logic [INCOME_W-1:0] heap_wdata;
    logic [IW-1:0]       heap_raddr;
    logic [INCOME_W-1:0] heap_rdata;

    logic [HAW-1:0]      due_c;
    logic                s_acc;
    logic                do_link;
    logic [HAW-1:0]      latest_new;
    logic [PW-1:0]       up;
    logic [PW:0]         c_idx;
    logic [PW:0]         c1_idx;
    logic [SUM_W:0]      sum_add;
    logic                pick_b;
    logic [INCOME_W-1:0] child_v;
    logic [PW:0]         child_i;

    djmi_ram #(.WIDTH(HW), .DEPTH(HD)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );

    djmi_ram #(.WIDTH(JW), .DEPTH(MAX_JOBS)) u_job (
        .clk(clk), .we(job_we), .waddr(job_waddr), .wdata(job_wdata),
        .raddr(job_raddr), .rdata(job_rdata)
    );

    djmi_ram #(.WIDTH(INCOME_W), .DEPTH(MAX_JOBS)) u_heap (
        .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .raddr(heap_raddr), .rdata(heap_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        if (32'(s_axis_tdata[INCOME_W +: DUE_W]) > MAX_DUE)
        begin
            due_c = HAW'(MAX_DUE);
        end
        else
        begin
            due_c = HAW'(s_axis_tdata[INCOME_W +: DUE_W]);
        end
    end

    assign do_link    = (32'(loaded_reg) < MAX_JOBS) && (in_due_reg != '0);
    assign latest_new = (32'(loaded_reg) < MAX_JOBS) && (in_due_reg > latest_reg)
                        ? in_due_reg : latest_reg;
    assign up         = (pos_reg - PW'(1)) >> 1;
    assign c_idx      = {pos_reg, 1'b1};
    assign c1_idx     = c_idx + (PW+1)'(1);
    assign sum_add    = {1'b0, sum_reg} + (SUM_W+1)'(top_reg);
    assign pick_b     = bval_reg && (heap_rdata > a_reg);
    assign child_v    = pick_b ? heap_rdata : a_reg;
    assign child_i    = pick_b ? c1_idx : c_idx;

    always_comb
    begin
        head_we    = 1'b0;
        head_waddr = day_reg;
        head_wdata = '0;
        head_raddr = day_reg;
        job_we     = 1'b0;
        job_waddr  = loaded_reg[IW-1:0];
        job_wdata  = {head_rdata, in_inc_reg};
        job_raddr  = nidx_reg;
        heap_we    = 1'b0;
        heap_waddr = pos_reg[IW-1:0];
        heap_wdata = v_reg;
        heap_raddr = '0;
        case (state_reg)
            S_CLR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
            end
            S_IDLE:
            begin
                head_raddr = due_c;
            end
            S_LINK:
            begin
                head_we    = do_link;
                head_waddr = in_due_reg;
                head_wdata = {1'b1, loaded_reg[IW-1:0]};
                job_we     = do_link;
            end
            S_DAY_CHK:
            begin
                head_we   = head_rdata[HW-1];
                job_raddr = head_rdata[IW-1:0];
            end
            S_PUSH_RD:
            begin
                heap_we    = (pos_reg == '0);
                heap_raddr = up[IW-1:0];
            end
            S_PUSH_CMP:
            begin
                heap_we    = 1'b1;
                heap_wdata = (heap_rdata >= v_reg) ? v_reg : heap_rdata;
            end
            S_POP_RD1:
            begin
                heap_raddr = IW'(count_reg - PW'(1));
            end
            S_SD_RD1:
            begin
                heap_we    = (c_idx >= {1'b0, count_reg});
                heap_raddr = c_idx[IW-1:0];
            end
            S_SD_RD2:
            begin
                heap_raddr = c1_idx[IW-1:0];
            end
            S_SD_CMP:
            begin
                heap_we    = 1'b1;
                heap_wdata = (child_v <= v_reg) ? v_reg : child_v;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            loaded_reg    <= '0;
            latest_reg    <= '0;
            day_reg       <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && state_reg != S_FINISH)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + HAW'(1);
                    if (32'(clr_reg) == MAX_DUE)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_acc)
                    begin
                        in_inc_reg  <= s_axis_tdata[INCOME_W-1:0];
                        in_due_reg  <= due_c;
                        in_last_reg <= s_axis_tlast;
                        state_reg   <= S_LINK;
                    end
                end
                S_LINK:
                begin
                    if (32'(loaded_reg) < MAX_JOBS)
                    begin
                        loaded_reg <= loaded_reg + PW'(1);
                    end
                    latest_reg <= latest_new;
                    day_reg    <= latest_new;
                    if (!in_last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (latest_new == '0)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_DAY_RD;
                    end
                end
                S_DAY_RD:
                begin
                    state_reg <= S_DAY_CHK;
                end
                S_DAY_CHK:
                begin
                    state_reg <= head_rdata[HW-1] ? S_JOB_CHK : S_POP_RD0;
                end
                S_JOB_CHK:
                begin
                    v_reg      <= job_rdata[INCOME_W-1:0];
                    nidx_reg   <= job_rdata[INCOME_W +: IW];
                    nvalid_reg <= job_rdata[JW-1];
                    pos_reg    <= count_reg;
                    count_reg  <= count_reg + PW'(1);
                    state_reg  <= S_PUSH_RD;
                end
                S_PUSH_RD:
                begin
                    if (pos_reg == '0)
                    begin
                        state_reg <= nvalid_reg ? S_JOB_CHK : S_POP_RD0;
                    end
                    else
                    begin
                        state_reg <= S_PUSH_CMP;
                    end
                end
                S_PUSH_CMP:
                begin
                    if (heap_rdata >= v_reg)
                    begin
                        state_reg <= nvalid_reg ? S_JOB_CHK : S_POP_RD0;
                    end
                    else
                    begin
                        pos_reg   <= up;
                        state_reg <= S_PUSH_RD;
                    end
                end
                S_POP_RD0:
                begin
                    state_reg <= (count_reg == '0) ? S_NEXT_DAY : S_POP_RD1;
                end
                S_POP_RD1:
                begin
                    top_reg   <= heap_rdata;
                    count_reg <= count_reg - PW'(1);
                    state_reg <= S_POP_V;
                end
                S_POP_V:
                begin
                    v_reg     <= heap_rdata;
                    pos_reg   <= '0;
                    sum_reg   <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                    state_reg <= S_SD_RD1;
                end
                S_SD_RD1:
                begin
                    state_reg <= (c_idx >= {1'b0, count_reg}) ? S_NEXT_DAY : S_SD_RD2;
                end
                S_SD_RD2:
                begin
                    a_reg     <= heap_rdata;
                    bval_reg  <= (c1_idx < {1'b0, count_reg});
                    state_reg <= S_SD_CMP;
                end
                S_SD_CMP:
                begin
                    if (child_v <= v_reg)
                    begin
                        state_reg <= S_NEXT_DAY;
                    end
                    else
                    begin
                        pos_reg   <= child_i[PW-1:0];
                        state_reg <= S_SD_RD1;
                    end
                end
                S_NEXT_DAY:
                begin
                    day_reg   <= day_reg - HAW'(1);
                    state_reg <= (day_reg == HAW'(1)) ? S_FINISH : S_DAY_RD;
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= sum_reg;
                        loaded_reg    <= '0;
                        latest_reg    <= '0;
                        count_reg     <= '0;
                        sum_reg       <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= loaded_reg)
        else $error("heap holds more entries than jobs loaded");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> count_reg == '0 && sum_reg == '0)
        else $error("set state not cleared while loading");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DAY_RD |-> day_reg <= latest_reg && day_reg != '0)
        else $error("day out of range");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> state_reg == S_IDLE)
        else $error("result issued outside of set completion");

endmodule

// ----- tb/sv/deadline_job_max_income_unit_tb.sv -----
`timescale 1ns / 1ps

module deadline_job_max_income_unit_tb;
    import djmi_pkg::*;

    localparam int MAX_JOBS   = 256;
    localparam int MAX_DUE    = 256;
    localparam int RAND_ITEMS = 475;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [INCOME_W-1:0] income;
        logic [DUE_W-1:0]    due;
        logic                last;
        logic                has_sum;
        logic [SUM_W-1:0]    sum;
    } job_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                s_axis_tlast;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [SUM_W-1:0]    m_axis_tdata;

    deadline_job_max_income_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    logic [INCOME_W-1:0] set_income[MAX_JOBS];
    logic [DUE_W-1:0]    set_due[MAX_JOBS];
    int                  set_len;
    logic [SUM_W-1:0]    sum_queue[$];
    logic [SUM_W-1:0]    pinned_queue[$];
    logic                pinned_flag[$];
    int                  errors = 0;
    int                  sets_done = 0;
    int                  cycles = 0;
    bit                  quiet;
    bit                  hold_off;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [SUM_W-1:0] best_income();
        logic [SUM_W-1:0] total;
        int best;
        bit taken[MAX_JOBS];
        total = '0;
        for (int k = 0; k < set_len; k++)
            taken[k] = 1'b0;
        for (int day = MAX_DUE; day > 0; day--)
        begin
            best = -1;
            for (int k = 0; k < set_len; k++)
                if (!taken[k] && set_due[k] >= day &&
                    (best < 0 || set_income[k] > set_income[best]))
                    best = k;
            if (best >= 0)
            begin
                taken[best] = 1'b1;
                if (total + set_income[best] > SUM_MAX)
                    total = SUM_MAX;
                else
                    total = total + set_income[best];
            end
        end
        return total;
    endfunction

    task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                   input logic [SUM_W-1:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    task automatic send_job(input logic [INCOME_W-1:0] income, input logic [DUE_W-1:0] due,
                            input logic last, input logic has_sum,
                            input logic [SUM_W-1:0] sum);
        int gap;
        logic [DUE_W-1:0] clamped;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, due, income};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        clamped = (due > MAX_DUE) ? DUE_W'(MAX_DUE) : due;
        if (set_len < MAX_JOBS)
        begin
            set_income[set_len] = income;
            set_due[set_len] = clamped;
            set_len++;
        end
        if (last)
        begin
            sum_queue = {sum_queue, best_income()};
            pinned_queue = {pinned_queue, sum};
            pinned_flag = {pinned_flag, has_sum};
            set_len = 0;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sum_queue.size() == 0)
            begin
                report_mismatch("unexpected beat", m_axis_tdata, '0);
            end
            else
            begin
                if (m_axis_tdata !== sum_queue[0])
                    report_mismatch("total_income", m_axis_tdata, sum_queue[0]);
                if (pinned_flag[0] && m_axis_tdata !== pinned_queue[0])
                    report_mismatch("table total_income", m_axis_tdata, pinned_queue[0]);
                void'(sum_queue.pop_front());
                void'(pinned_queue.pop_front());
                void'(pinned_flag.pop_front());
                sets_done++;
            end
        end
    end

    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 10);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    job_row_t directed[] = '{
        '{16'd5,     9'd1,   1'b1, 1'b1, 24'd5},
        '{16'd0,     9'd0,   1'b1, 1'b1, 24'd0},
        '{16'hFFFF,  9'd0,   1'b1, 1'b1, 24'd0},
        '{16'hFFFF,  9'd256, 1'b1, 1'b1, 24'd65535},
        '{16'hFFFF,  9'd511, 1'b1, 1'b1, 24'd65535},
        '{16'd100,   9'd1,   1'b0, 1'b0, 24'd0},
        '{16'd300,   9'd1,   1'b0, 1'b0, 24'd0},
        '{16'd200,   9'd1,   1'b1, 1'b1, 24'd300},
        '{16'd10,    9'd2,   1'b0, 1'b0, 24'd0},
        '{16'd20,    9'd1,   1'b0, 1'b0, 24'd0},
        '{16'd30,    9'd2,   1'b0, 1'b0, 24'd0},
        '{16'd40,    9'd0,   1'b1, 1'b0, 24'd0},
        '{16'hAAAA,  9'h155, 1'b0, 1'b0, 24'd0},
        '{16'h5555,  9'h0AA, 1'b0, 1'b0, 24'd0},
        '{16'h8001,  9'd3,   1'b0, 1'b0, 24'd0},
        '{16'h7FFE,  9'd257, 1'b1, 1'b0, 24'd0}
    };

    initial
    begin
        int n;
        int len;
        int due_max;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        set_len = 0;
        quiet = 1'b0;
        hold_off = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_job(directed[i].income, directed[i].due, directed[i].last,
                     directed[i].has_sum, directed[i].sum);

        for (int k = 0; k < MAX_JOBS + 3; k++)
            send_job(16'hFFFF, 9'd256, k == MAX_JOBS + 2, 1'b1, 24'hFFFF00);

        hold_off = 1'b1;
        n = 0;
        while (n < RAND_ITEMS)
        begin
            if (n > RAND_ITEMS * 4 / 5)
                quiet = 1'b1;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
            due_max = ($urandom_range(0, 3) == 0) ? 511 : $urandom_range(1, 12);
            for (int k = 0; k < len; k++)
                send_job(16'($urandom), 9'($urandom_range(0, due_max)), k == len - 1,
                         1'b0, '0);
            n += len;
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;

        while (sum_queue.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d job sets: empty-due, clamped, overflow and full-store cases",
                 sets_done);
        $display("random sets with short and long due ranges under both-side stalls");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- sim.f -----
sv/djmi_pkg.sv
sv/djmi_ram.sv
sv/deadline_job_max_income_unit.sv
tb/sv/deadline_job_max_income_unit_tb.sv
